// File: rtl/core/arbe_pkg.sv
// ----------------------------------------------------------------------------
// arbe_pkg
// Types and constants shared by the alternating run bit expander.
// ----------------------------------------------------------------------------
package arbe_pkg;

  localparam int unsigned PIX_W = 8;
  localparam logic [2:0]  SLOT_MSB = 3'd7;

  typedef struct packed {
    logic [7:0] run_length;
    logic       end_of_frame;
  } arbe_in_t;

  typedef struct packed {
    logic [7:0] pixel_byte;
    logic       last_of_item;
    logic       frame_done;
  } arbe_out_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } arbe_state_e;

  // result of one pass of the fill unit
  typedef struct packed {
    logic [7:0] partial;
    logic [2:0] slot;
    logic       full;
  } arbe_fill_t;

endpackage

// File: rtl/core/arbe_fill_unit.sv
// ----------------------------------------------------------------------------
// arbe_fill_unit
// Places up to one byte's worth of pixels of the current color into the
// accumulator and reports how many pixels of the run are left.
// ----------------------------------------------------------------------------
module arbe_fill_unit #(
  parameter int unsigned RUN_BITS = 8
) (
  input  logic [7:0]          partial_i,
  input  logic [2:0]          slot_i,
  input  logic                color_i,
  input  logic [RUN_BITS-1:0] remain_i,
  output logic [RUN_BITS-1:0] remain_o,
  output arbe_pkg::arbe_fill_t fill_o
);

  localparam int unsigned CW = (RUN_BITS > 4) ? RUN_BITS : 4;

  logic [CW-1:0] remain_ext;
  logic [CW-1:0] avail_ext;
  logic [CW-1:0] remain_sub;
  logic [3:0]    avail;
  logic [3:0]    take;
  logic [7:0]    mask;

  assign avail      = {1'b0, slot_i} + 4'd1;
  assign remain_ext = CW'(remain_i);
  assign avail_ext  = CW'(avail);
  assign take       = (remain_ext >= avail_ext) ? avail : remain_ext[3:0];
  assign remain_sub = remain_ext - CW'(take);
  assign remain_o   = remain_sub[RUN_BITS-1:0];

  // pixel positions covered by this pass: slot down to slot - take + 1
  always_comb begin
    for (int j = 0; j < 8; j++) begin
      mask[j] = (3'(j) <= slot_i) && (({1'b0, 3'(j)} + take) >= avail);
    end
  end

  always_comb begin
    fill_o.partial = partial_i | (color_i ? mask : 8'h00);
    fill_o.full    = (take == avail);
    fill_o.slot    = fill_o.full ? arbe_pkg::SLOT_MSB : (slot_i - take[2:0]);
  end

endmodule

// File: rtl/core/alternating_run_bit_expander.sv
// ----------------------------------------------------------------------------
// alternating_run_bit_expander
// Expands alternating black/white run lengths into packed 1 bpp pixel bytes.
// ----------------------------------------------------------------------------
// An accepted run is worked off by a single fill unit that places up to eight
// pixels per cycle. An item is taken while idle, worked off one pass per byte
// it touches and closed by a pass that flips the color or ends the frame; no
// new run is taken until the block is idle again. A pass that completes a byte
// waits while the output register still holds an untaken byte. Each byte
// leaves through a registered output, most significant bit first; the final
// byte of an item carries last_of_item, and an end-of-frame item flushes a
// zero-padded partial byte with frame_done, then restarts black and empty.
module alternating_run_bit_expander #(
  parameter int unsigned RUN_BITS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  arbe_pkg::arbe_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output arbe_pkg::arbe_out_t out_data_o
);

  localparam int unsigned CW_EXT = (RUN_BITS > 4) ? RUN_BITS : 4;

  arbe_pkg::arbe_state_e state_q, state_d;

  logic                color_q, color_d;
  logic [2:0]          slot_q, slot_d;
  logic [7:0]          partial_q, partial_d;
  logic [RUN_BITS-1:0] remain_q, remain_d;
  logic                eof_q, eof_d;
  logic                out_valid_q, out_valid_d;
  arbe_pkg::arbe_out_t out_q, out_d;

  logic [RUN_BITS-1:0] run_w;
  logic [RUN_BITS-1:0] remain_nxt;
  arbe_pkg::arbe_fill_t fill;
  logic                out_free;
  logic                run_done;
  logic                need_flush;
  logic                rest_short;

  // keep the low RUN_BITS bits of the run length, zero-extended when RUN_BITS exceeds 8
  always_comb begin
    run_w = '0;
    for (int i = 0; i < RUN_BITS; i++) begin
      if (i < 8) begin
        run_w[i] = in_data_i.run_length[i];
      end
    end
  end

  arbe_fill_unit #(
    .RUN_BITS (RUN_BITS)
  ) u_fill (
    .partial_i (partial_q),
    .slot_i    (slot_q),
    .color_i   (color_q),
    .remain_i  (remain_q),
    .remain_o  (remain_nxt),
    .fill_o    (fill)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign run_done   = (remain_q == '0);
  assign need_flush = eof_q && (slot_q != arbe_pkg::SLOT_MSB);
  // after a full byte the next pass starts at bit 7 and fills a byte only
  // if eight or more pixels remain
  assign rest_short = (CW_EXT'(remain_nxt) < CW_EXT'(arbe_pkg::PIX_W));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      arbe_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = arbe_pkg::ST_RUN;
        end
      end
      arbe_pkg::ST_RUN: begin
        if (run_done && (!need_flush || out_free)) begin
          state_d = arbe_pkg::ST_IDLE;
        end
      end
      default: state_d = arbe_pkg::ST_IDLE;
    endcase
  end

  // datapath and output register control
  always_comb begin
    color_d     = color_q;
    slot_d      = slot_q;
    partial_d   = partial_q;
    remain_d    = remain_q;
    eof_d       = eof_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    case (state_q)
      arbe_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          remain_d = run_w;
          eof_d    = in_data_i.end_of_frame;
        end
      end
      arbe_pkg::ST_RUN: begin
        if (!run_done) begin
          if (out_free || !fill.full) begin
            remain_d = remain_nxt;
            slot_d   = fill.slot;
            if (fill.full) begin
              partial_d          = '0;
              out_valid_d        = 1'b1;
              out_d.pixel_byte   = fill.partial;
              out_d.last_of_item = rest_short && (!eof_q || (remain_nxt == '0));
              out_d.frame_done   = eof_q && (remain_nxt == '0);
            end else begin
              partial_d = fill.partial;
            end
          end
        end else if (eof_q) begin
          if (!need_flush || out_free) begin
            if (need_flush) begin
              out_valid_d        = 1'b1;
              out_d.pixel_byte   = partial_q;
              out_d.last_of_item = 1'b1;
              out_d.frame_done   = 1'b1;
            end
            color_d   = 1'b0;
            slot_d    = arbe_pkg::SLOT_MSB;
            partial_d = '0;
          end
        end else begin
          color_d = !color_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= arbe_pkg::ST_IDLE;
      color_q     <= 1'b0;
      slot_q      <= arbe_pkg::SLOT_MSB;
      partial_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      color_q     <= color_d;
      slot_q      <= slot_d;
      partial_q   <= partial_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    remain_q <= remain_d;
    eof_q    <= eof_d;
    out_q    <= out_d;
  end

  assign in_stall_o  = (state_q != arbe_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
